/* src/pps_pkg.sv */
// Shared types and constants for the pure pursuit steering block.
// Used by pps_front, pps_back and the top level.
package pps_pkg;

    localparam int FRAC_BITS = 16;
    localparam int REG_W     = 20;
    localparam int POS_W     = 24;
    localparam int LIN_W     = 21;
    localparam int TURN_W    = 24;
    localparam int NUM_REGS  = 7;
    localparam int ADDR_W    = 5;
    localparam int SQ_W      = 48;
    localparam int DEN_W     = 49;
    localparam int NUM_W     = 68;

    localparam logic [TURN_W-2:0] TURN_SAT = '1;

    // register indexes
    localparam logic [2:0] REG_SPEED_MAX = 3'd0;
    localparam logic [2:0] REG_SPEED_MIN = 3'd1;
    localparam logic [2:0] REG_RAMP_ST   = 3'd2;
    localparam logic [2:0] REG_RAMP_END  = 3'd3;
    localparam logic [2:0] REG_ARRIVE    = 3'd4;
    localparam logic [2:0] REG_HALF_TRK  = 3'd5;
    localparam logic [2:0] REG_STRAIGHT  = 3'd6;

    localparam logic [REG_W-1:0] RST_SPEED_MAX = 20'd9830;
    localparam logic [REG_W-1:0] RST_SPEED_MIN = 20'd3277;
    localparam logic [REG_W-1:0] RST_RAMP_ST   = 20'd19661;
    localparam logic [REG_W-1:0] RST_RAMP_END  = 20'd9830;
    localparam logic [REG_W-1:0] RST_ARRIVE    = 20'd655;
    localparam logic [REG_W-1:0] RST_HALF_TRK  = 20'd10813;
    localparam logic [REG_W-1:0] RST_STRAIGHT  = 20'd197;

    // command codes
    localparam logic CMD_NEW_GOAL = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    typedef struct packed {
        logic [REG_W-1:0] speed_max;
        logic [REG_W-1:0] speed_min;
        logic [REG_W-1:0] ramp_start;
        logic [REG_W-1:0] ramp_end;
        logic [REG_W-1:0] arrive_tol;
        logic [REG_W-1:0] half_track;
        logic [REG_W-1:0] straight_band;
    } t_cfg;

    typedef struct packed {
        logic              command;
        logic [POS_W-1:0]  goal_y;
        logic [POS_W-1:0]  goal_x;
    } t_item;

    typedef struct packed {
        logic              goal_active;
        logic [TURN_W-1:0] turn_rate;
        logic [LIN_W-1:0]  linear_speed;
    } t_result;

endpackage

/* src/pps_front.sv */
// Front end: takes input transfers into a two-entry queue.
// Depends on pps_pkg for the item type.
module pps_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pps_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output pps_pkg::t_item o_item
);

    pps_pkg::t_item r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // store the item and advance the pointers
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

/* src/pps_back.sv */
// Back end: sequencer with one shared multiplier, a digit-serial square root
// and a shared restoring divider. Depends on pps_pkg.
module pps_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pps_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  pps_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output pps_pkg::t_result o_result
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_SQX   = 14'b00000000000010,
        S_SQY   = 14'b00000000000100,
        S_SQRT  = 14'b00000000001000,
        S_CHK   = 14'b00000000010000,
        S_RMUL  = 14'b00000000100000,
        S_DIV   = 14'b00000001000000,
        S_RDONE = 14'b00000010000000,
        S_DEN   = 14'b00000100000000,
        S_VLO   = 14'b00001000000000,
        S_VHI   = 14'b00010000000000,
        S_WSET  = 14'b00100000000000,
        S_WDONE = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    localparam int PW = pps_pkg::POS_W;
    localparam int RW = pps_pkg::REG_W;

    t_state r_state, r_ret;
    logic              r_flag;
    logic [PW-1:0]     r_ax, r_ay, r_yeff, r_root;
    logic              r_xneg, r_yneg, r_vneg, r_wneg, r_dneg;
    logic [pps_pkg::SQ_W-1:0]  r_s, r_sh;
    logic [PW+1:0]     r_srem;
    logic [4:0]        r_cnt;
    logic [RW-1:0]     r_m;
    logic [pps_pkg::DEN_W-1:0] r_dvs, r_rem;
    logic [PW-1:0]     r_nsh, r_q;
    logic [43:0]       r_acc;
    logic [RW-1:0]     r_v;
    logic [PW-2:0]     r_w;

    logic [PW-1:0]     mul_a, mul_b;
    logic [2*PW-1:0]   prod;
    logic [PW+1:0]     sq_cur, sq_trial;
    logic [pps_pkg::DEN_W:0] dv_t;
    logic [pps_pkg::DEN_W-1:0] den;
    logic [pps_pkg::NUM_W-1:0] num_v, num_w;
    logic [RW:0]       dspan;
    logic [RW-1:0]     span_mag;
    logic [PW-1:0]     ax_in, ay_in;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_result.goal_active  = ~r_flag;
    assign o_result.linear_speed = r_vneg ? -{1'b0, r_v} : {1'b0, r_v};
    assign o_result.turn_rate    = r_wneg ? -{1'b0, r_w} : {1'b0, r_w};

    assign ax_in = i_item.goal_x[PW-1] ? -i_item.goal_x : i_item.goal_x;
    assign ay_in = i_item.goal_y[PW-1] ? -i_item.goal_y : i_item.goal_y;

    // speed span, signed
    assign dspan    = {1'b0, i_cfg.speed_max} - {1'b0, i_cfg.speed_min};
    assign span_mag = dspan[RW] ? RW'(-dspan) : dspan[RW-1:0];

    // shared multiplier operand selection
    always_comb begin
        mul_a = r_m + PW'(0);
        mul_b = r_s[PW-1:0];
        case (r_state)
            S_SQX:   begin mul_a = r_ax;   mul_b = r_ax; end
            S_SQY:   begin mul_a = r_ay;   mul_b = r_ay; end
            S_RMUL:  begin mul_a = r_root - PW'(i_cfg.ramp_end); mul_b = PW'(span_mag); end
            S_DEN:   begin mul_a = r_yeff; mul_b = PW'(i_cfg.half_track); end
            S_VLO:   begin mul_a = PW'(r_m); mul_b = r_s[PW-1:0]; end
            S_VHI:   begin mul_a = PW'(r_m); mul_b = r_s[2*PW-1:PW]; end
            S_WSET:  begin mul_a = PW'(r_m); mul_b = r_yeff; end
            default: begin mul_a = PW'(r_m); mul_b = r_s[PW-1:0]; end
        endcase
    end
    assign prod = mul_a * mul_b;

    // square root digit and divider step
    assign sq_cur   = {r_srem[PW-1:0], r_sh[pps_pkg::SQ_W-1 -: 2]};
    assign sq_trial = {r_root, 2'b01};
    assign dv_t     = {r_rem, r_nsh[PW-1]};

    assign den   = r_s + pps_pkg::DEN_W'({prod[43:0], 2'b00});
    assign num_v = pps_pkg::NUM_W'(r_acc) + (pps_pkg::NUM_W'(prod[43:0]) << PW);
    assign num_w = pps_pkg::NUM_W'(prod[43:0]) << (pps_pkg::FRAC_BITS + 2);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_flag  <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ax   <= ax_in;
                        r_ay   <= ay_in;
                        r_xneg <= i_item.goal_x[PW-1];
                        r_yneg <= i_item.goal_y[PW-1];
                        if (i_item.command == pps_pkg::CMD_NEW_GOAL) begin
                            r_flag  <= 1'b0;
                            r_v     <= '0;
                            r_w     <= '0;
                            r_vneg  <= 1'b0;
                            r_wneg  <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SQX;
                        end
                    end
                end
                S_SQX: begin
                    r_s     <= prod;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_s     <= r_s + prod;
                    r_sh    <= r_s + prod;
                    r_srem  <= '0;
                    r_root  <= '0;
                    r_cnt   <= 5'd24;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    // one result bit per cycle
                    if (sq_cur >= sq_trial) begin
                        r_srem <= sq_cur - sq_trial;
                        r_root <= {r_root[PW-2:0], 1'b1};
                    end else begin
                        r_srem <= sq_cur;
                        r_root <= {r_root[PW-2:0], 1'b0};
                    end
                    r_sh  <= r_sh << 2;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) r_state <= S_CHK;
                end
                S_CHK: begin
                    // on arrival both magnitudes are zero, so the signs do not matter
                    r_yeff <= (r_ay > PW'(i_cfg.straight_band)) ? r_ay : '0;
                    r_vneg <= r_xneg;
                    r_wneg <= r_yneg ^ r_xneg;
                    if (r_root < PW'(i_cfg.arrive_tol)) begin
                        r_flag  <= 1'b1;
                        r_v     <= '0;
                        r_w     <= '0;
                        r_state <= S_OUT;
                    end else if (r_root > PW'(i_cfg.ramp_start)) begin
                        r_m     <= i_cfg.speed_max;
                        r_state <= S_DEN;
                    end else if (r_root < PW'(i_cfg.ramp_end)
                                 || i_cfg.ramp_start <= i_cfg.ramp_end) begin
                        r_m     <= i_cfg.speed_min;
                        r_state <= S_DEN;
                    end else begin
                        r_state <= S_RMUL;
                    end
                end
                S_RMUL: begin
                    // quotient stays below 2^20 as the offset is within the span
                    r_dneg  <= dspan[RW];
                    r_dvs   <= pps_pkg::DEN_W'(i_cfg.ramp_start - i_cfg.ramp_end);
                    r_rem   <= pps_pkg::DEN_W'(prod >> RW);
                    r_nsh   <= PW'(prod << (PW - RW));
                    r_q     <= '0;
                    r_cnt   <= 5'(RW);
                    r_ret   <= S_RDONE;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (dv_t >= {1'b0, r_dvs}) begin
                        r_rem <= pps_pkg::DEN_W'(dv_t - {1'b0, r_dvs});
                        r_q   <= {r_q[PW-2:0], 1'b1};
                    end else begin
                        r_rem <= dv_t[pps_pkg::DEN_W-1:0];
                        r_q   <= {r_q[PW-2:0], 1'b0};
                    end
                    r_nsh <= r_nsh << 1;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) r_state <= r_ret;
                end
                S_RDONE: begin
                    r_m     <= r_dneg ? i_cfg.speed_min - r_q[RW-1:0]
                                      : i_cfg.speed_min + r_q[RW-1:0];
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_dvs <= den;
                    if (den == '0) begin
                        r_v     <= r_m;
                        r_w     <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_VLO;
                    end
                end
                S_VLO: begin
                    r_acc   <= prod[43:0];
                    r_state <= S_VHI;
                end
                S_VHI: begin
                    // linear speed never exceeds the limit, so 21 quotient bits
                    r_rem   <= pps_pkg::DEN_W'(num_v >> (RW + 1));
                    r_nsh   <= PW'(num_v << (PW - RW - 1));
                    r_q     <= '0;
                    r_cnt   <= 5'(RW + 1);
                    r_ret   <= S_WSET;
                    r_state <= S_DIV;
                end
                S_WSET: begin
                    r_v <= r_q[RW-1:0];
                    if ((num_w >> (PW - 1)) >= pps_pkg::NUM_W'(r_dvs)) begin
                        r_w     <= pps_pkg::TURN_SAT;
                        r_state <= S_OUT;
                    end else begin
                        r_rem   <= pps_pkg::DEN_W'(num_w >> (PW - 1));
                        r_nsh   <= PW'(num_w << 1);
                        r_q     <= '0;
                        r_cnt   <= 5'(PW - 1);
                        r_ret   <= S_WDONE;
                        r_state <= S_DIV;
                    end
                end
                S_WDONE: begin
                    r_w     <= r_q[PW-2:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* src/pure_pursuit_speed_limited_steering.sv */
// Top level: configuration registers, front queue, back sequencer, output register.
// Depends on pps_pkg, pps_front and pps_back.
//
//   port group   dir   transfer when        contents
//   s_axis_*     in    tvalid && tready     goal_x, goal_y in tdata; command in tuser
//   m_axis_*     out   tvalid && tready     linear_speed, turn_rate, goal_active
//   APB          in    psel&penable&pwrite  seven 20-bit registers at 4*i
//
// A new-goal item skips the arithmetic. A control tick runs a 24-step square root and,
// unless it arrives, up to three serial divisions (20, 21 and 23 steps) on one shared
// divider. Reset is synchronous and active low; it restores the register defaults and
// marks no goal active. The input queue holds two items while the output stalls.
module pure_pursuit_speed_limited_steering (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // goal_x[23:0], goal_y[47:24]
    input  logic        s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // linear_speed[20:0], turn_rate[44:21],
                                        // goal_active[45], zero[47:46]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [pps_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pps_pkg::t_cfg    r_cfg;
    pps_pkg::t_item   in_item, q_item;
    pps_pkg::t_result b_res, r_res;
    logic q_valid, q_ready, b_valid, b_ready, r_ovalid;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_max     <= pps_pkg::RST_SPEED_MAX;
            r_cfg.speed_min     <= pps_pkg::RST_SPEED_MIN;
            r_cfg.ramp_start    <= pps_pkg::RST_RAMP_ST;
            r_cfg.ramp_end      <= pps_pkg::RST_RAMP_END;
            r_cfg.arrive_tol    <= pps_pkg::RST_ARRIVE;
            r_cfg.half_track    <= pps_pkg::RST_HALF_TRK;
            r_cfg.straight_band <= pps_pkg::RST_STRAIGHT;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                pps_pkg::REG_SPEED_MAX: r_cfg.speed_max     <= pwdata[19:0];
                pps_pkg::REG_SPEED_MIN: r_cfg.speed_min     <= pwdata[19:0];
                pps_pkg::REG_RAMP_ST:   r_cfg.ramp_start    <= pwdata[19:0];
                pps_pkg::REG_RAMP_END:  r_cfg.ramp_end      <= pwdata[19:0];
                pps_pkg::REG_ARRIVE:    r_cfg.arrive_tol    <= pwdata[19:0];
                pps_pkg::REG_HALF_TRK:  r_cfg.half_track    <= pwdata[19:0];
                pps_pkg::REG_STRAIGHT:  r_cfg.straight_band <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[4:2])
            pps_pkg::REG_SPEED_MAX: prdata = 32'(r_cfg.speed_max);
            pps_pkg::REG_SPEED_MIN: prdata = 32'(r_cfg.speed_min);
            pps_pkg::REG_RAMP_ST:   prdata = 32'(r_cfg.ramp_start);
            pps_pkg::REG_RAMP_END:  prdata = 32'(r_cfg.ramp_end);
            pps_pkg::REG_ARRIVE:    prdata = 32'(r_cfg.arrive_tol);
            pps_pkg::REG_HALF_TRK:  prdata = 32'(r_cfg.half_track);
            pps_pkg::REG_STRAIGHT:  prdata = 32'(r_cfg.straight_band);
            default:                prdata = 32'd0;
        endcase
    end

    assign in_item.command = s_axis_tuser;
    assign in_item.goal_x  = s_axis_tdata[23:0];
    assign in_item.goal_y  = s_axis_tdata[47:24];

    pps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    pps_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_item   (q_item),
        .o_valid  (b_valid),
        .i_ready  (b_ready),
        .o_result (b_res)
    );

    // output register: load when empty or being drained
    assign b_ready = !r_ovalid || m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (b_valid && b_ready) begin
            r_res <= b_res;
        end
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (b_ready) begin
            r_ovalid <= b_valid;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_res};

endmodule

/* dv/pure_pursuit_speed_limited_steering_tb.sv */
// Self-checking testbench for the pure pursuit steering block: streams goal points,
// predicts each speed command in-bench and compares every output transfer.
// Depends on pps_pkg and the pure_pursuit_speed_limited_steering RTL.
module pure_pursuit_speed_limited_steering_tb;
    import pps_pkg::*;

    localparam logic [2:0] REG_UNMAPPED = 3'd7;
    localparam int         CYCLE_LIMIT  = 1500000;
    localparam int         DRAIN_WAIT   = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pure_pursuit_speed_limited_steering u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state: register copy and sticky arrival flag
    logic [REG_W-1:0] steer_regs [NUM_REGS];
    logic             goal_reached;
    t_result          pending_cmds [$];
    int               error_count = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    logic             hold_toggle = 1'b0;
    int               cycle_count = 0;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [63:0] scaled_ratio(input logic [63:0] a, input logic [63:0] b,
                                                 input logic [63:0] c);
        logic [127:0] prod;
        logic [127:0] quot;
        if (c == 0)
            return '1;
        prod = {64'd0, a} * {64'd0, b};
        quot = prod / {64'd0, c};
        if (quot[127:64] != 0)
            return '1;
        return quot[63:0];
    endfunction

    function automatic longint ramp_speed(input longint d);
        longint smax, smin, rs, re, span;
        smax = steer_regs[REG_SPEED_MAX];
        smin = steer_regs[REG_SPEED_MIN];
        rs   = steer_regs[REG_RAMP_ST];
        re   = steer_regs[REG_RAMP_END];
        if (d > rs)
            return smax;
        if (d < re)
            return smin;
        span = rs - re;
        if (span <= 0)
            return smin;
        return smin + ((d - re) * (smax - smin)) / span;
    endfunction

    // work out the wheel command for one goal and update the arrival flag
    function automatic t_result steer_command(input logic cmd, input logic [POS_W-1:0] gx,
                                              input logic [POS_W-1:0] gy);
        t_result     r;
        longint      x, y, d, m;
        logic [63:0] ax, ay, sq, yeff, den, vmag, wmag;
        r = '0;
        if (cmd == CMD_NEW_GOAL) begin
            goal_reached = 1'b0;
            r.goal_active = 1'b1;
            return r;
        end
        x = longint'($signed(gx));
        y = longint'($signed(gy));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        sq = ax * ax + ay * ay;
        d = longint'(floor_sqrt(sq));
        if (d < longint'(steer_regs[REG_ARRIVE])) begin
            goal_reached = 1'b1;
            return r;
        end
        m = ramp_speed(d);
        yeff = (ay > steer_regs[REG_STRAIGHT]) ? ay : 64'd0;
        den = sq + 4 * yeff * steer_regs[REG_HALF_TRK];
        if (den == 0) begin
            vmag = m;
            wmag = 0;
        end else begin
            vmag = scaled_ratio(m, sq, den);
            wmag = scaled_ratio(4 * m * yeff, 64'd1 << FRAC_BITS, den);
        end
        if (vmag > 64'd1048575)
            vmag = 64'd1048575;
        if (wmag > 64'(TURN_SAT))
            wmag = 64'(TURN_SAT);
        r.linear_speed = (x < 0) ? LIN_W'(-vmag) : LIN_W'(vmag);
        r.turn_rate    = ((y < 0) != (x < 0)) ? TURN_W'(-wmag) : TURN_W'(wmag);
        r.goal_active  = !goal_reached;
        return r;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin : receive_side
        static logic seen_toggle = 1'b0;
        static int   hold_left = 0;
        t_result     got, want;
        if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left = 400;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[45:0];
            if (pending_cmds.size() == 0) begin
                $error("unexpected result transfer %h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (got.linear_speed !== want.linear_speed) begin
                    $error("linear_speed expected %0d actual %0d",
                           $signed(want.linear_speed), $signed(got.linear_speed));
                    error_count++;
                end
                if (got.turn_rate !== want.turn_rate) begin
                    $error("turn_rate expected %0d actual %0d",
                           $signed(want.turn_rate), $signed(got.turn_rate));
                    error_count++;
                end
                if (got.goal_active !== want.goal_active) begin
                    $error("goal_active expected %0b actual %0b",
                           want.goal_active, got.goal_active);
                    error_count++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [REG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx < NUM_REGS)
            steer_regs[idx] = val;
    endtask

    // send one goal transfer and queue its expected command
    task automatic send_goal(input logic cmd, input logic [POS_W-1:0] gx,
                             input logic [POS_W-1:0] gy);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {gy, gx};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_cmds.push_back(steer_command(cmd, gx, gy));
    endtask

    // stop sending and let every result and any trailing work finish
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [POS_W-1:0] rand_coord;
        case ($urandom_range(3))
            0:       return POS_W'($urandom);
            1:       return POS_W'(int'($urandom_range(524288)) - 262144);
            2:       return POS_W'(int'($urandom_range(8192)) - 4096);
            default: return POS_W'(int'($urandom_range(600)) - 300);
        endcase
    endfunction

    function automatic logic [REG_W-1:0] rand_reg(input int typical);
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return REG_W'($urandom);
            default: return REG_W'($urandom_range(typical * 2));
        endcase
    endfunction

    task automatic test_directed;
        drain();
        write_reg(REG_SPEED_MAX, '1);
        write_reg(REG_UNMAPPED, 20'h12345);
        send_goal(CMD_NEW_GOAL, '0, '0);
        send_goal(CMD_TICK, 24'h7FFFFF, 24'h7FFFFF);
        send_goal(CMD_TICK, 24'h800000, 24'h800000);
        send_goal(CMD_TICK, 24'h800000, 24'h7FFFFF);
        send_goal(CMD_TICK, 24'd30000, 24'd100);        // inside straight band
        send_goal(CMD_TICK, -24'sd30000, 24'd5000);     // reversing
        send_goal(CMD_TICK, 24'd15000, -24'sd9000);     // on the ramp
        send_goal(CMD_TICK, 24'd10, 24'd10);            // arrives
        send_goal(CMD_TICK, 24'd40000, 24'd40000);      // sticky flag holds
        send_goal(CMD_NEW_GOAL, 24'h7FFFFF, 24'h800000);
        send_goal(CMD_TICK, 24'd40000, 24'd40000);
        drain();
        // zero distance with zero tolerance, and turn rate overflow
        write_reg(REG_ARRIVE, '0);
        write_reg(REG_HALF_TRK, '0);
        write_reg(REG_STRAIGHT, '0);
        send_goal(CMD_TICK, '0, '0);
        send_goal(CMD_TICK, '0, 24'd1);
        send_goal(CMD_TICK, 24'd1, -24'sd2);
        drain();
        // equal ramp bounds, then inverted ones
        write_reg(REG_RAMP_ST, 20'd5000);
        write_reg(REG_RAMP_END, 20'd5000);
        write_reg(REG_SPEED_MIN, 20'd100);
        send_goal(CMD_TICK, 24'd3000, 24'd4000);
        send_goal(CMD_TICK, 24'd3000, 24'd4001);
        drain();
        write_reg(REG_RAMP_ST, 20'd1000);
        write_reg(REG_RAMP_END, 20'd90000);
        send_goal(CMD_TICK, 24'd3000, 24'd4000);
        send_goal(CMD_TICK, 24'd600, 24'd800);
        send_goal(CMD_TICK, 24'd200000, 24'd800);
        drain();
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        drain();
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_reg(REG_SPEED_MAX, rand_reg(9830));
        write_reg(REG_SPEED_MIN, rand_reg(3277));
        write_reg(REG_RAMP_ST, rand_reg(19661));
        write_reg(REG_RAMP_END, rand_reg(9830));
        write_reg(REG_ARRIVE, ($urandom_range(7) == 0) ? rand_reg(655) :
                              REG_W'($urandom_range(1300)));
        write_reg(REG_HALF_TRK, rand_reg(10813));
        write_reg(REG_STRAIGHT, rand_reg(197));
        for (int n = 0; n < count; n++)
            send_goal(($urandom_range(9) == 0) ? CMD_NEW_GOAL : CMD_TICK,
                      rand_coord(), rand_coord());
    endtask

    // stall the output for a long stretch while the input keeps offering
    task automatic test_hold_off;
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_toggle <= !hold_toggle;
        for (int n = 0; n < 12; n++)
            send_goal(n[0] ? CMD_TICK : CMD_NEW_GOAL, rand_coord(), rand_coord());
        drain();
    endtask

    initial begin
        steer_regs[REG_SPEED_MAX] = RST_SPEED_MAX;
        steer_regs[REG_SPEED_MIN] = RST_SPEED_MIN;
        steer_regs[REG_RAMP_ST]   = RST_RAMP_ST;
        steer_regs[REG_RAMP_END]  = RST_RAMP_END;
        steer_regs[REG_ARRIVE]    = RST_ARRIVE;
        steer_regs[REG_HALF_TRK]  = RST_HALF_TRK;
        steer_regs[REG_STRAIGHT]  = RST_STRAIGHT;
        goal_reached = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset settings first
        send_goal(CMD_TICK, 24'd30000, 24'd8000);
        send_goal(CMD_NEW_GOAL, '0, '0);
        send_goal(CMD_TICK, 24'd30000, 24'd8000);
        test_directed();
        test_hold_off();
        for (int k = 0; k < 3; k++) test_random(60, 31, 86);
        for (int k = 0; k < 3; k++) test_random(60, 86, 31);
        for (int k = 0; k < 3; k++) test_random(60, 0, 0);
        drain();
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
src/pps_pkg.sv
src/pps_front.sv
src/pps_back.sv
src/pure_pursuit_speed_limited_steering.sv
dv/pure_pursuit_speed_limited_steering_tb.sv
